// ===== rtl/tt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tt_pkg;

	localparam int TABLE_SLOTS_DEF = 16;

	localparam int NUMBER_W = 32;
	localparam int HANDLE_W = 48;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_GENERATE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VERIFY   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REVOKE   = 2'd2;

	// result codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FREE,
		ST_MATCH,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/tt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ticket_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// ticket_table: bounded table of issued tickets, one identifier/handle pair per slot.
// Input channel (in_valid / in_stall) carries one item: mode, ticket_number, handle_value.
// Output channel (out_valid / out_stall) returns one result item per input item:
// status, issued_number, bound_handle.
// Items are handled one at a time. A generate walks the live bits one slot a cycle
// and takes the lowest free slot, answering full if none is free. Verify and revoke
// stream the slot memory (one read port, registered read data) and stop at the
// lowest live match, answering not found if none matches. Mode 3 answers not
// found. in_stall is high while an item is in flight.
// The result waits in an output register; a stalled receiver holds it there, and
// the next item is accepted meanwhile but its result waits until the register frees.
// Reset clears all live bits, the identifier counter and the output valid at once;
// no clearing pass is needed and the slot memory itself is never cleared.

module ticket_table
	import tt_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [NUMBER_W-1:0] ticket_number,
	input  wire logic [HANDLE_W-1:0] handle_value,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      logic [STATUS_W-1:0] status,
	output      logic [NUMBER_W-1:0] issued_number,
	output      logic [HANDLE_W-1:0] bound_handle
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam int ENT_W = NUMBER_W + HANDLE_W;
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_SLOTS);

	state_t state_q, state_d;

	// item under work
	logic [MODE_W-1:0]   mode_q;
	logic [NUMBER_W-1:0] number_q;
	logic [HANDLE_W-1:0] handle_q;

	// table state
	logic [TABLE_SLOTS-1:0] live_q;
	logic [NUMBER_W-1:0]    next_number_q;

	// scan control
	logic [CNT_W-1:0] cnt_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] chk_idx_s1;

	// pending result
	logic [STATUS_W-1:0] res_status_q;
	logic [NUMBER_W-1:0] res_issued_q;
	logic [HANDLE_W-1:0] res_bound_q;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [NUMBER_W-1:0] issued_q;
	logic [HANDLE_W-1:0] bound_q;

	// memory ports
	logic             ram_wr_en;
	logic             ram_rd_en;
	logic [IDX_W-1:0] cnt_idx;
	logic [ENT_W-1:0] ram_wr_data;
	logic [ENT_W-1:0] ram_rd_data;
	logic [NUMBER_W-1:0] rd_number;
	logic [HANDLE_W-1:0] rd_handle;

	// decisions
	logic in_take;
	logic out_load;
	logic scan_end;
	logic free_hit;
	logic match_hit;
	logic match_miss;

	assign cnt_idx   = cnt_q[IDX_W-1:0];
	assign rd_number = ram_rd_data[ENT_W-1:HANDLE_W];
	assign rd_handle = ram_rd_data[HANDLE_W-1:0];

	tt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (cnt_idx),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (cnt_idx),
		.rd_data (ram_rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_GENERATE) begin
						state_d = ST_FREE;
					end else if (mode == MODE_VERIFY || mode == MODE_REVOKE) begin
						state_d = ST_MATCH;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_FREE: begin
				if (scan_end || free_hit) begin
					state_d = ST_RESP;
				end
			end
			ST_MATCH: begin
				if (match_hit || match_miss) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and datapath controls
	always_comb begin
		in_stall    = 1'b1;
		in_take     = 1'b0;
		out_load    = 1'b0;
		scan_end    = (cnt_q == CNT_END);
		free_hit    = 1'b0;
		match_hit   = 1'b0;
		match_miss  = 1'b0;
		ram_wr_en   = 1'b0;
		ram_rd_en   = 1'b0;
		ram_wr_data = {next_number_q, handle_q};
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				in_take  = in_valid;
			end
			ST_FREE: begin
				free_hit  = !scan_end && !live_q[cnt_idx];
				ram_wr_en = free_hit;
			end
			ST_MATCH: begin
				ram_rd_en  = !scan_end;
				match_hit  = chk_vld_s1 && live_q[chk_idx_s1] && (rd_number == number_q)
					&& ((mode_q != MODE_VERIFY) || (rd_handle == handle_q));
				match_miss = !chk_vld_s1 && scan_end;
			end
			ST_RESP: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			live_q        <= '0;
			next_number_q <= '0;
			chk_vld_s1    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (free_hit) begin
				live_q[cnt_idx] <= 1'b1;
				next_number_q   <= next_number_q + NUMBER_W'(1);
			end
			if (match_hit && (mode_q == MODE_REVOKE)) begin
				live_q[chk_idx_s1] <= 1'b0;
			end
			// track whether a read is coming back next cycle
			chk_vld_s1 <= ram_rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q       <= mode;
			number_q     <= ticket_number;
			handle_q     <= handle_value;
			cnt_q        <= '0;
			res_status_q <= STAT_NOT_FOUND;
			res_issued_q <= '0;
			res_bound_q  <= '0;
		end
		if (state_q == ST_FREE) begin
			if (scan_end) begin
				res_status_q <= STAT_FULL;
			end else if (free_hit) begin
				res_status_q <= STAT_OK;
				res_issued_q <= next_number_q;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
		if (ram_rd_en) begin
			// advance the read address; hold the slot index for the compare
			cnt_q      <= cnt_q + CNT_W'(1);
			chk_idx_s1 <= cnt_idx;
		end
		if (match_hit) begin
			res_status_q <= STAT_OK;
			res_bound_q  <= (mode_q == MODE_VERIFY) ? rd_handle : '0;
		end
		if (out_load) begin
			status_q <= res_status_q;
			issued_q <= res_issued_q;
			bound_q  <= res_bound_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign issued_number = issued_q;
	assign bound_handle  = bound_q;

endmodule

`default_nettype wire
